>>> rtl/byte_ring_fifo_with_linear_span_defines.svh
// Assertion macros shared by the byte ring FIFO RTL.
`ifndef BYTE_RING_FIFO_WITH_LINEAR_SPAN_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_LINEAR_SPAN_DEFINES_SVH

`ifndef SYNTHESIS

`define BRF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("brf assertion failed");

`define BRF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("brf assertion failed");

`else

`define BRF_ASSERT(lbl, clk, rst, prop)

`define BRF_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> rtl/brf_pkg.sv
// Shared widths, operation codes and state type of the byte ring FIFO.
package brf_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int FUNC_W  = 2;
   localparam int DATA_W  = 8;
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;
   localparam int DROP_W  = 32;

   localparam logic [FUNC_W-1:0] FUNC_PUT     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET     = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WRAP,
      ST_SEND
   } brf_state_type;

endpackage

>>> rtl/byte_ring_fifo_with_linear_span.sv
// Top level of the byte ring FIFO with contiguous span report.
//
//   channel  prefix  direction  carries
//   request  req_    in         func, data_byte, advance_count
//   response rsp_    out        status, read_byte, counts, positions, drops
//
// Put, get and unused codes pass through the exec and send steps; advance adds a wrap step.
// The next request is taken the cycle after the result is loaded into rsp_.
// The registered store read port and the two-step modulo of the advance set these steps.
// Synchronous reset clears pointers and drop counter; store contents stay undefined.
// A stalled response holds the block in its send step until rsp_ready.
`include "byte_ring_fifo_with_linear_span_defines.svh"

module byte_ring_fifo_with_linear_span #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [brf_pkg::FUNC_W-1:0]  req_func,
   input  logic [brf_pkg::DATA_W-1:0]  req_data_byte,
   input  logic [brf_pkg::COUNT_W-1:0] req_advance_count,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic [brf_pkg::DATA_W-1:0]  rsp_read_byte,
   output logic [brf_pkg::POS_W-1:0]   rsp_fill_count,
   output logic [brf_pkg::POS_W-1:0]   rsp_linear_count,
   output logic [brf_pkg::POS_W-1:0]   rsp_write_position,
   output logic [brf_pkg::POS_W-1:0]   rsp_read_position,
   output logic [brf_pkg::DROP_W-1:0]  rsp_dropped_count
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(DEPTH);

   brf_pkg::brf_state_type state_ff, state_in;

   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [brf_pkg::DROP_W-1:0]  drop_ff, drop_in;
   logic [brf_pkg::FUNC_W-1:0]  func_ff;
   logic [brf_pkg::DATA_W-1:0]  data_ff;
   logic                        status_ff, status_in;
   logic [brf_pkg::DATA_W-1:0]  got_ff, got_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff;
   logic [brf_pkg::DATA_W-1:0]  rsp_read_byte_ff;
   logic [brf_pkg::POS_W-1:0]   rsp_fill_ff;
   logic [brf_pkg::POS_W-1:0]   rsp_linear_ff;
   logic [brf_pkg::POS_W-1:0]   rsp_wpos_ff;
   logic [brf_pkg::POS_W-1:0]   rsp_rpos_ff;
   logic [brf_pkg::DROP_W-1:0]  rsp_drop_ff;

   logic                        req_fire;
   logic                        rsp_load;
   logic                        mem_we;
   logic [brf_pkg::DATA_W-1:0]  mem_rd_data;
   logic [AW-1:0]               adv_ptr;
   logic [AW-1:0]               wr_bump;
   logic [AW-1:0]               rd_bump;
   logic [AW:0]                 fill;
   logic [AW:0]                 linear;

   brf_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (data_ff),
      .rd_en   (req_fire),
      .rd_addr (rd_ptr_ff),
      .rd_data (mem_rd_data)
   );

   brf_adv #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_adv (
      .clock       (clock),
      .load        (req_fire),
      .count       (req_advance_count),
      .rd_ptr      (rd_ptr_ff),
      .rd_ptr_next (adv_ptr)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = brf_pkg::ST_EXEC;
            end
         end
         brf_pkg::ST_EXEC: begin
            if (func_ff == brf_pkg::FUNC_ADVANCE) begin
               state_in = brf_pkg::ST_WRAP;
            end else begin
               state_in = brf_pkg::ST_SEND;
            end
         end
         brf_pkg::ST_WRAP: begin
            state_in = brf_pkg::ST_SEND;
         end
         brf_pkg::ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = brf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         brf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         brf_pkg::ST_SEND: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign req_fire = req_valid && req_ready;
   assign wr_bump  = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
   assign rd_bump  = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      drop_in   = drop_ff;
      status_in = status_ff;
      got_in    = got_ff;
      mem_we    = 1'b0;
      case (state_ff)
         brf_pkg::ST_EXEC: begin
            status_in = 1'b0;
            got_in    = '0;
            case (func_ff)
               brf_pkg::FUNC_PUT: begin
                  if (wr_bump == rd_ptr_ff) begin
                     drop_in   = drop_ff + brf_pkg::DROP_W'(1);
                     status_in = 1'b1;
                  end else begin
                     mem_we    = 1'b1;
                     wr_ptr_in = wr_bump;
                  end
               end
               brf_pkg::FUNC_GET: begin
                  if (rd_ptr_ff == wr_ptr_ff) begin
                     status_in = 1'b1;
                  end else begin
                     got_in    = mem_rd_data;
                     rd_ptr_in = rd_bump;
                  end
               end
               brf_pkg::FUNC_ADVANCE: begin
                  status_in = 1'b0;
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end
         brf_pkg::ST_WRAP: begin
            rd_ptr_in = adv_ptr;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (wr_ptr_ff >= rd_ptr_ff) begin
         fill   = (AW+1)'(wr_ptr_ff) - (AW+1)'(rd_ptr_ff);
         linear = fill;
      end else begin
         fill   = DEPTH_X + (AW+1)'(wr_ptr_ff) - (AW+1)'(rd_ptr_ff);
         linear = DEPTH_X - (AW+1)'(rd_ptr_ff);
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brf_pkg::ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      got_ff    <= got_in;
      if (req_fire) begin
         func_ff <= req_func;
         data_ff <= req_data_byte;
      end
      if (rsp_load) begin
         rsp_status_ff    <= status_ff;
         rsp_read_byte_ff <= got_ff;
         rsp_fill_ff      <= brf_pkg::POS_W'(fill);
         rsp_linear_ff    <= brf_pkg::POS_W'(linear);
         rsp_wpos_ff      <= brf_pkg::POS_W'(wr_ptr_ff);
         rsp_rpos_ff      <= brf_pkg::POS_W'(rd_ptr_ff);
         rsp_drop_ff      <= drop_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_byte      = rsp_read_byte_ff;
   assign rsp_fill_count     = rsp_fill_ff;
   assign rsp_linear_count   = rsp_linear_ff;
   assign rsp_write_position = rsp_wpos_ff;
   assign rsp_read_position  = rsp_rpos_ff;
   assign rsp_dropped_count  = rsp_drop_ff;

   `BRF_ASSERT(a_accept_to_exec, clock, reset, req_fire |=> state_ff == brf_pkg::ST_EXEC)
   `BRF_ASSERT(a_drop_only_on_put, clock, reset, !(state_ff == brf_pkg::ST_EXEC && func_ff == brf_pkg::FUNC_PUT) |=> $stable(drop_ff))
   `BRF_ASSERT(a_wrap_holds_write, clock, reset, state_ff == brf_pkg::ST_WRAP |=> $stable(wr_ptr_ff))
   `BRF_ASSERT(a_send_loads, clock, reset, rsp_load |=> rsp_valid_ff && state_ff == brf_pkg::ST_IDLE)
   `BRF_ASSERT_ALWAYS(a_ptr_range, clock, (wr_ptr_ff <= LAST) || reset)

endmodule

>>> rtl/brf_store.sv
// Byte store: one write port, one read port with registered read data.
module brf_store #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [brf_pkg::DATA_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [brf_pkg::DATA_W-1:0] rd_data
);

   logic [brf_pkg::DATA_W-1:0] mem [DEPTH];
   logic [brf_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/brf_adv.sv
// Read pointer advance: count modulo depth by reciprocal multiply, then wrapped add.
module brf_adv #(
   parameter int DEPTH = brf_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [brf_pkg::COUNT_W-1:0] count,
   input  logic [AW-1:0]               rd_ptr,
   output logic [AW-1:0]               rd_ptr_next
);

   localparam int CW = brf_pkg::COUNT_W;
   localparam int PW = CW + 33;
   localparam int SW = ((AW > CW) ? AW : CW) + 1;
   localparam logic [32:0] RECIP = 33'(((64'd1 << 32) / DEPTH) + 64'd1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   logic [PW-1:0] prod;
   logic [CW-1:0] quot_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] rem_in;
   logic [CW-1:0] rem_ff;
   logic [SW-1:0] sum;

   assign prod = PW'(count) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff <= prod[32+CW-1:32];
         cnt_ff  <= count;
      end
   end

   assign rem_in = cnt_ff - CW'(quot_ff * DEPTH_C);

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   always_comb begin
      sum = SW'(rd_ptr) + SW'(rem_ff);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      rd_ptr_next = AW'(sum);
   end

endmodule

>>> tb/byte_ring_fifo_with_linear_span_test.sv
// Self-checking test of the byte ring FIFO: a ring mirror predicts every response.
`timescale 1ns / 100ps

localparam int RING_DEPTH = brf_pkg::DEPTH_DEFAULT;
localparam logic [brf_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
localparam logic STATUS_OK   = 1'b0;
localparam logic STATUS_FAIL = 1'b1;
localparam int MISMATCH_SHOWN = 10;

typedef struct {
   logic                       status;
   logic [brf_pkg::DATA_W-1:0] read_byte;
   logic [brf_pkg::POS_W-1:0]  fill;
   logic [brf_pkg::POS_W-1:0]  span;
   logic [brf_pkg::POS_W-1:0]  wr_pos;
   logic [brf_pkg::POS_W-1:0]  rd_pos;
   logic [brf_pkg::DROP_W-1:0] drops;
} ring_result_type;

class ring_mirror_type;
   logic [brf_pkg::DATA_W-1:0] bytes_held [RING_DEPTH];
   bit                         was_written [RING_DEPTH];
   int                         wr_idx;
   int                         rd_idx;
   logic [brf_pkg::DROP_W-1:0] drop_total;
   ring_result_type            results_due [$];
   int                         mismatches;

   function new();
      wr_idx = 0;
      rd_idx = 0;
      drop_total = '0;
      mismatches = 0;
      foreach (was_written[i]) was_written[i] = 1'b0;
   endfunction

   function int fill();
      return (wr_idx >= rd_idx) ? wr_idx - rd_idx : RING_DEPTH + wr_idx - rd_idx;
   endfunction

   function int span();
      return (wr_idx >= rd_idx) ? wr_idx - rd_idx : RING_DEPTH - rd_idx;
   endfunction

   function bit busy();
      return results_due.size() != 0;
   endfunction

   function bit get_is_safe();
      return rd_idx == wr_idx || was_written[rd_idx];
   endfunction

   function void apply_ring_op(logic [brf_pkg::FUNC_W-1:0] f,
                               logic [brf_pkg::DATA_W-1:0] d,
                               logic [brf_pkg::COUNT_W-1:0] c);
      ring_result_type r;
      int nxt;
      r.status = STATUS_OK;
      r.read_byte = '0;
      case (f)
         brf_pkg::FUNC_PUT: begin
            nxt = (wr_idx + 1) % RING_DEPTH;
            if (nxt == rd_idx) begin
               drop_total = drop_total + 1'b1;
               r.status = STATUS_FAIL;
            end else begin
               bytes_held[wr_idx] = d;
               was_written[wr_idx] = 1'b1;
               wr_idx = nxt;
            end
         end
         brf_pkg::FUNC_GET: begin
            if (rd_idx == wr_idx) begin
               r.status = STATUS_FAIL;
            end else begin
               r.read_byte = bytes_held[rd_idx];
               rd_idx = (rd_idx + 1) % RING_DEPTH;
            end
         end
         brf_pkg::FUNC_ADVANCE: begin
            rd_idx = (rd_idx + int'(c) % RING_DEPTH) % RING_DEPTH;
         end
         default: begin
            r.status = STATUS_FAIL;
         end
      endcase
      r.fill = brf_pkg::POS_W'(fill());
      r.span = brf_pkg::POS_W'(span());
      r.wr_pos = brf_pkg::POS_W'(wr_idx);
      r.rd_pos = brf_pkg::POS_W'(rd_idx);
      r.drops = drop_total;
      results_due.push_back(r);
   endfunction

   function void match_ring_result(ring_result_type got);
      ring_result_type want;
      if (results_due.size() == 0) begin
         mismatches++;
         if (mismatches <= MISMATCH_SHOWN)
            $display("%0t: response with nothing outstanding", $realtime);
         return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status || got.read_byte !== want.read_byte ||
          got.fill !== want.fill || got.span !== want.span ||
          got.wr_pos !== want.wr_pos || got.rd_pos !== want.rd_pos ||
          got.drops !== want.drops) begin
         mismatches++;
         if (mismatches <= MISMATCH_SHOWN) begin
            $display("%0t: expected st=%b rd=%h fill=%0d span=%0d wp=%0d rp=%0d drop=%0d",
                     $realtime, want.status, want.read_byte, want.fill, want.span,
                     want.wr_pos, want.rd_pos, want.drops);
            $display("%0t: actual   st=%b rd=%h fill=%0d span=%0d wp=%0d rp=%0d drop=%0d",
                     $realtime, got.status, got.read_byte, got.fill, got.span,
                     got.wr_pos, got.rd_pos, got.drops);
         end
      end
   endfunction
endclass

module byte_ring_fifo_with_linear_span_test;

   localparam int ITEM_TARGET = 1900;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [brf_pkg::FUNC_W-1:0]  req_func = brf_pkg::FUNC_PUT;
   logic [brf_pkg::DATA_W-1:0]  req_data_byte = '0;
   logic [brf_pkg::COUNT_W-1:0] req_advance_count = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_status;
   logic [brf_pkg::DATA_W-1:0]  rsp_read_byte;
   logic [brf_pkg::POS_W-1:0]   rsp_fill_count;
   logic [brf_pkg::POS_W-1:0]   rsp_linear_count;
   logic [brf_pkg::POS_W-1:0]   rsp_write_position;
   logic [brf_pkg::POS_W-1:0]   rsp_read_position;
   logic [brf_pkg::DROP_W-1:0]  rsp_dropped_count;

   ring_mirror_type mirror = new();
   int              ops_sent = 0;
   bit              steady = 1'b0;

   byte_ring_fifo_with_linear_span u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_data_byte      (req_data_byte),
      .req_advance_count  (req_advance_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_linear_count   (rsp_linear_count),
      .rsp_write_position (rsp_write_position),
      .rsp_read_position  (rsp_read_position),
      .rsp_dropped_count  (rsp_dropped_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 17);
   end

   always @(posedge clock) begin
      ring_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.read_byte = rsp_read_byte;
         got.fill = rsp_fill_count;
         got.span = rsp_linear_count;
         got.wr_pos = rsp_write_position;
         got.rd_pos = rsp_read_position;
         got.drops = rsp_dropped_count;
         mirror.match_ring_result(got);
      end
   end

   task automatic push_op(logic [brf_pkg::FUNC_W-1:0] f, logic [brf_pkg::DATA_W-1:0] d,
                          logic [brf_pkg::COUNT_W-1:0] c);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 17) gap = int'($urandom_range(1, 4));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_data_byte <= d;
      req_advance_count <= c;
      do @(posedge clock); while (!req_ready);
      mirror.apply_ring_op(f, d, c);
      ops_sent++;
      steady = (ops_sent >= 1300 && ops_sent < 1600);
   endtask

   task automatic push_noise(logic [brf_pkg::FUNC_W-1:0] f);
      push_op(f, brf_pkg::DATA_W'($urandom_range(0, 255)),
              brf_pkg::COUNT_W'($urandom_range(0, 2047)));
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mirror.busy()) @(posedge clock);
   endtask

   task automatic random_op();
      int pick;
      logic [brf_pkg::FUNC_W-1:0]  f;
      logic [brf_pkg::COUNT_W-1:0] c;
      pick = int'($urandom_range(0, 99));
      c = brf_pkg::COUNT_W'($urandom_range(0, 2047));
      if (pick < 42) begin
         f = brf_pkg::FUNC_PUT;
      end else if (pick < 74) begin
         f = brf_pkg::FUNC_GET;
      end else if (pick < 95) begin
         f = brf_pkg::FUNC_ADVANCE;
         case ($urandom_range(0, 3))
            0, 1: c = brf_pkg::COUNT_W'(mirror.span());
            2: c = brf_pkg::COUNT_W'($urandom_range(0, mirror.fill()));
            default: c = c;
         endcase
      end else begin
         f = FUNC_UNUSED;
      end
      if (f == brf_pkg::FUNC_GET && !mirror.get_is_safe()) f = brf_pkg::FUNC_PUT;
      push_op(f, brf_pkg::DATA_W'($urandom_range(0, 255)), c);
   endtask

   task automatic burst_op();
      logic [brf_pkg::FUNC_W-1:0] f;
      int n;
      f = $urandom_range(0, 1) ? brf_pkg::FUNC_PUT : brf_pkg::FUNC_GET;
      n = int'($urandom_range(20, 80));
      repeat (n) begin
         if (f == brf_pkg::FUNC_GET && !mirror.get_is_safe()) push_noise(brf_pkg::FUNC_PUT);
         else push_noise(f);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_noise(brf_pkg::FUNC_GET);
      push_noise(FUNC_UNUSED);
      push_op(brf_pkg::FUNC_PUT, 8'h00, brf_pkg::COUNT_W'($urandom_range(0, 2047)));
      push_op(brf_pkg::FUNC_PUT, 8'hFF, brf_pkg::COUNT_W'($urandom_range(0, 2047)));
      push_op(brf_pkg::FUNC_PUT, 8'hA5, brf_pkg::COUNT_W'($urandom_range(0, 2047)));
      push_noise(brf_pkg::FUNC_GET);
      push_noise(brf_pkg::FUNC_GET);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd0);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd1024);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd1);
      push_noise(brf_pkg::FUNC_GET);
      push_op(brf_pkg::FUNC_PUT, 8'h5A, brf_pkg::COUNT_W'($urandom_range(0, 2047)));
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd2047);
      push_noise(brf_pkg::FUNC_GET);
      push_noise(brf_pkg::FUNC_GET);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd1023);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd5);
      push_op(brf_pkg::FUNC_ADVANCE, brf_pkg::DATA_W'($urandom_range(0, 255)), 11'd1020);
      push_noise(brf_pkg::FUNC_GET);

      while (mirror.fill() < RING_DEPTH - 1) begin
         if ($urandom_range(0, 9) == 0 && mirror.get_is_safe()) push_noise(brf_pkg::FUNC_GET);
         else push_noise(brf_pkg::FUNC_PUT);
      end
      repeat (6) push_noise(brf_pkg::FUNC_PUT);
      push_noise(brf_pkg::FUNC_GET);
      push_noise(brf_pkg::FUNC_PUT);
      push_noise(brf_pkg::FUNC_PUT);

      drain_wait();

      while (ops_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 24) == 0) burst_op();
         else random_op();
      end

      drain_wait();
      repeat (10) @(posedge clock);
      if (mirror.mismatches == 0 && !mirror.busy()) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
